// ----- rtl/mie_pkg.sv -----
package mie_pkg;

	localparam int FIELD_W  = 63;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_INVERSE   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_ARGUMENT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_FINISH,
		ST_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_ALIGN,
		DV_DIV
	} div_state_t;

endpackage

// ----- rtl/mie_req_if.sv -----
interface mie_req_if import mie_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] modulus;
	logic [FIELD_W-1:0] value;

	modport source (output valid, output modulus, output value, input ready);
	modport sink (input valid, input modulus, input value, output ready);
endinterface

// ----- rtl/mie_rsp_if.sv -----
interface mie_rsp_if import mie_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIELD_W-1:0]  inverse_value;
	logic [FIELD_W-1:0]  gcd_value;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output inverse_value, output gcd_value, output status,
		input ready);
	modport sink (input valid, input inverse_value, input gcd_value, input status,
		output ready);
endinterface

// ----- rtl/mie_qdiv.sv -----
module mie_qdiv import mie_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	input  logic [W-1:0] coef,
	output logic         done,
	output logic [W-1:0] remainder,
	output logic [W-1:0] product
);

	localparam int KW = $clog2(W);

	div_state_t    state_q;
	div_state_t    state_d;
	logic [W-1:0]  r_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  t_q;
	logic [KW-1:0] k_q;
	logic          done_q;
	logic          fits;
	logic          ge;
	logic          load;
	logic          grow;
	logic          step;

	// divisor may still double without passing the partial remainder
	assign fits = !d_q[W-1] && ({d_q[W-2:0], 1'b0} <= r_q);
	assign ge   = r_q >= d_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: begin
				if (start) state_d = DV_ALIGN;
			end
			DV_ALIGN: begin
				if (!fits) state_d = DV_DIV;
			end
			DV_DIV: begin
				if (k_q == '0) state_d = DV_IDLE;
			end
			default: state_d = DV_IDLE;
		endcase
	end

	always_comb begin
		load = 1'b0;
		grow = 1'b0;
		step = 1'b0;
		unique case (state_q)
			DV_IDLE:  load = start;
			DV_ALIGN: grow = fits;
			DV_DIV:   step = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= step && (k_q == '0);
			if (load) k_q <= '0;
			else if (grow) k_q <= k_q + KW'(1);
			else if (step) k_q <= k_q - KW'(1);
		end
	end

	// one quotient bit per cycle, coefficient product built msb first
	always_ff @(posedge clk) begin
		if (load) begin
			r_q <= dividend;
			d_q <= divisor;
			t_q <= '0;
		end else if (grow) begin
			d_q <= {d_q[W-2:0], 1'b0};
		end else if (step) begin
			if (ge) r_q <= r_q - d_q;
			t_q <= {t_q[W-2:0], 1'b0} + (ge ? coef : '0);
			d_q <= {1'b0, d_q[W-1:1]};
		end
	end

	assign done      = done_q;
	assign remainder = r_q;
	assign product   = t_q;

endmodule

// ----- rtl/modular_inverse_ext_euclid_core.sv -----
// a bad argument goes straight to ST_OUT; otherwise each euclid step runs ST_START, then
//   ST_WAIT while the divider aligns and divides; the last step is followed by ST_FINISH and ST_OUT
// throughput: one request at a time, the next is taken once the result is taken
// the serial quotient unit (one quotient bit per cycle) sets the step time
// reset: arst_n clears the control state at once; data registers are not reset
module modular_inverse_ext_euclid_core import mie_pkg::*; #(
	parameter int OPERAND_WIDTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	mie_req_if.sink   req,
	mie_rsp_if.source rsp
);

	localparam int W = OPERAND_WIDTH;

	top_state_t          state_q;
	top_state_t          state_d;
	logic [W-1:0]        rp_q;
	logic [W-1:0]        rc_q;
	logic [W-1:0]        cp_q;
	logic [W-1:0]        cc_q;
	logic [W-1:0]        m_q;
	logic [FIELD_W-1:0]  inv_q;
	logic [FIELD_W-1:0]  gcd_q;
	logic [STATUS_W-1:0] status_q;
	logic [W-1:0]        m_in;
	logic [W-1:0]        v_in;
	logic                bad;
	logic                accept;
	logic                div_start;
	logic                div_done;
	logic [W-1:0]        div_rem;
	logic [W-1:0]        div_prod;
	logic                rem_zero;
	logic [W-1:0]        lifted;
	logic                ready;
	logic                valid;

	assign m_in     = {1'b0, req.modulus[W-2:0]};
	assign v_in     = {1'b0, req.value[W-2:0]};
	assign bad      = (v_in == '0) || (v_in >= m_in);
	assign accept   = req.valid && ready;
	assign rem_zero = div_rem == '0;
	assign lifted   = cp_q[W-1] ? cp_q + m_q : cp_q;

	mie_qdiv #(
		.W(W)
	) u_qdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rp_q),
		.divisor  (rc_q),
		.coef     (cc_q),
		.done     (div_done),
		.remainder(div_rem),
		.product  (div_prod)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = bad ? ST_OUT : ST_START;
			end
			ST_START: state_d = ST_WAIT;
			ST_WAIT: begin
				if (div_done) state_d = rem_zero ? ST_FINISH : ST_START;
			end
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: begin
				if (rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready     = 1'b0;
		valid     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:  ready = 1'b1;
			ST_START: div_start = 1'b1;
			ST_OUT:   valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			rp_q <= m_in;
			rc_q <= v_in;
			cp_q <= '0;
			cc_q <= W'(1);
			m_q  <= m_in;
			if (bad) begin
				inv_q    <= '0;
				gcd_q    <= '0;
				status_q <= STATUS_BAD_ARGUMENT;
			end
		end else if (state_q == ST_WAIT && div_done) begin
			rp_q <= rc_q;
			rc_q <= div_rem;
			cp_q <= cc_q;
			cc_q <= cp_q - div_prod;
		end else if (state_q == ST_FINISH) begin
			gcd_q <= FIELD_W'(rp_q);
			if (rp_q != W'(1)) begin
				inv_q    <= '0;
				status_q <= STATUS_NO_INVERSE;
			end else begin
				inv_q    <= FIELD_W'(lifted);
				status_q <= STATUS_OK;
			end
		end
	end

	assign req.ready         = ready;
	assign rsp.valid         = valid;
	assign rsp.inverse_value = inv_q;
	assign rsp.gcd_value     = gcd_q;
	assign rsp.status        = status_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import mie_pkg::*;

	localparam int OPW = 64;
	localparam logic [63:0] OPERAND_MASK = (64'd1 << (OPW - 1)) - 64'd1;
	localparam logic [FIELD_W-1:0] FMAX = {FIELD_W{1'b1}};
	localparam int RANDOM_REQUESTS = 850;
	localparam int DRAIN_CYCLES = 600;
	localparam int EMPTY_WAIT_LIMIT = 40000;

	typedef struct packed {
		logic [FIELD_W-1:0]  inverse_value;
		logic [FIELD_W-1:0]  gcd_value;
		logic [STATUS_W-1:0] status;
	} inv_result_t;

	typedef struct packed {
		logic [FIELD_W-1:0] modulus;
		logic [FIELD_W-1:0] value;
		logic               typed;
		inv_result_t        result;
	} inv_row_t;

	localparam inv_result_t BAD = '{63'd0, 63'd0, STATUS_BAD_ARGUMENT};
	localparam inv_result_t NONE = '{63'd0, 63'd0, STATUS_OK};

	logic clk;
	logic arst_n;

	mie_req_if req_if ();
	mie_rsp_if rsp_if ();

	modular_inverse_ext_euclid_core #(.OPERAND_WIDTH(OPW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	inv_row_t directed_rows [19] = '{
		'{63'd5, 63'd0, 1'b1, BAD},
		'{63'd0, 63'd0, 1'b1, BAD},
		'{63'd0, 63'd9, 1'b1, BAD},
		'{63'd7, 63'd7, 1'b1, BAD},
		'{63'd3, 63'd10, 1'b1, BAD},
		'{63'd1, 63'd1, 1'b1, BAD},
		'{FMAX, FMAX, 1'b1, BAD},
		'{63'd2, 63'd1, 1'b1, '{63'd1, 63'd1, STATUS_OK}},
		'{FMAX, 63'd1, 1'b1, '{63'd1, 63'd1, STATUS_OK}},
		'{FMAX, FMAX - 63'd1, 1'b1, '{FMAX - 63'd1, 63'd1, STATUS_OK}},
		'{63'd12, 63'd8, 1'b1, '{63'd0, 63'd4, STATUS_NO_INVERSE}},
		'{FMAX, 63'd7, 1'b0, NONE},
		'{63'd7540113804746346429, 63'd4660046610375530309, 1'b0, NONE},
		'{63'h4000_0000_0000_0000, 63'h3FFF_FFFF_FFFF_FFFF, 1'b0, NONE},
		'{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, NONE},
		'{FMAX, 63'h4000_0000_0000_0000, 1'b0, NONE},
		'{63'd1000000007, 63'd123456789, 1'b0, NONE},
		'{63'h4000_0000_0000_0000, 63'h2000_0000_0000_0000, 1'b0, NONE},
		'{63'd17, 63'd16, 1'b0, NONE}
	};

	inv_result_t expected_results [$];
	inv_result_t want;
	int fail_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int status_seen [3] = '{0, 0, 0};
	int req_idle_pct = 35;
	int rsp_stall_pct = 46;

	function automatic inv_result_t predict_inverse(logic [FIELD_W-1:0] m_in,
		logic [FIELD_W-1:0] v_in);
		logic [63:0] m, v, rem_prev, rem_cur, co_prev, co_cur, q, nxt_rem, nxt_co;
		inv_result_t r;
		m = {1'b0, m_in} & OPERAND_MASK;
		v = {1'b0, v_in} & OPERAND_MASK;
		if (v == 64'd0 || v >= m) begin
			return BAD;
		end
		rem_prev = m;
		rem_cur = v;
		co_prev = 64'd0;
		co_cur = 64'd1;
		while (rem_cur != 64'd0) begin
			q = rem_prev / rem_cur;
			nxt_rem = rem_prev - q * rem_cur;
			nxt_co = co_prev - q * co_cur;
			rem_prev = rem_cur;
			rem_cur = nxt_rem;
			co_prev = co_cur;
			co_cur = nxt_co;
		end
		r.gcd_value = rem_prev[FIELD_W-1:0];
		if (rem_prev != 64'd1) begin
			r.inverse_value = '0;
			r.status = STATUS_NO_INVERSE;
		end else begin
			if (co_prev[63])
				co_prev = co_prev + m;
			r.inverse_value = co_prev[FIELD_W-1:0];
			r.status = STATUS_OK;
		end
		return r;
	endfunction

	function automatic logic [63:0] rand_bits(int len);
		return {$urandom, $urandom} & ((64'd1 << len) - 64'd1);
	endfunction

	function automatic logic [63:0] rand_operand();
		return rand_bits(($urandom_range(99) < 60) ? 63 : $urandom_range(63, 2));
	endfunction

	task automatic send_request(logic [FIELD_W-1:0] m, logic [FIELD_W-1:0] v, logic typed,
		inv_result_t typed_result);
		while ($urandom_range(99) < req_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.modulus <= m;
		req_if.value <= v;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		expected_results.push_back(typed ? typed_result : predict_inverse(m, v));
		requests_sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (rsp_if.status < 3)
						status_seen[rsp_if.status]++;
					if (rsp_if.inverse_value !== want.inverse_value) begin
						$error("inverse_value: expected %0d, got %0d", want.inverse_value,
							rsp_if.inverse_value);
						fail_count++;
					end
					if (rsp_if.gcd_value !== want.gcd_value) begin
						$error("gcd_value: expected %0d, got %0d", want.gcd_value,
							rsp_if.gcd_value);
						fail_count++;
					end
					if (rsp_if.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_if.status);
						fail_count++;
					end
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	initial begin
		logic [63:0] m, v, g, a, b, t;
		int len, waited;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.modulus = '0;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].modulus, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].result);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS / 3) begin
				req_idle_pct = 46;
				rsp_stall_pct = 35;
			end
			if (i == 2 * RANDOM_REQUESTS / 3) begin
				req_idle_pct = 0;
				rsp_stall_pct = 0;
			end
			m = rand_operand();
			if (m < 64'd2)
				m = 64'd2;
			v = 64'd1 + ({$urandom, $urandom} % (m - 64'd1));
			case ($urandom_range(99)) inside
				[0:9]: begin
					case ($urandom_range(3))
						0: v = 64'd0;
						1: v = m;
						2: begin
							t = m;
							m = v;
							v = t;
						end
						default: m = 64'd0;
					endcase
				end
				[10:29]: begin
					len = $urandom_range(31, 1);
					g = rand_bits(len);
					if (g < 64'd2)
						g = 64'd2;
					a = rand_bits(63 - len);
					if (a < 64'd2)
						a = 64'd2;
					b = 64'd1 + ({$urandom, $urandom} % (a - 64'd1));
					m = g * a;
					v = g * b;
				end
				default: ;
			endcase
			send_request(m[FIELD_W-1:0], v[FIELD_W-1:0], 1'b0, NONE);
		end
		req_if.valid <= 1'b0;

		waited = 0;
		while (expected_results.size() != 0 && waited < EMPTY_WAIT_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests (%0d directed) sent, %0d results checked, %0d mismatches",
			requests_sent, $size(directed_rows), results_checked, fail_count);
		$display("status mix: %0d inverse found, %0d no inverse, %0d bad argument",
			status_seen[STATUS_OK], status_seen[STATUS_NO_INVERSE],
			status_seen[STATUS_BAD_ARGUMENT]);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
